FILE: rtl/rsnh_pkg.sv
// Shared widths, constants and pipeline sideband types for the ray-sphere hit unit.
package rsnh_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int CW   = COORD_WIDTH;
    localparam int LW   = CW + 1;
    localparam int RADW = CW - 1;
    localparam int AW   = 2 * CW;
    localparam int HW   = 2 * CW + 2;
    localparam int CSW  = 2 * CW + 3;
    localparam int MH   = CW + 1;
    localparam int MW   = 2 * MH;
    localparam int PW   = 2 * MH;
    localparam int DW   = 4 * CW + 4;
    localparam int SQW  = DW / 2;
    localparam int NW   = 2 * CW + 4;
    localparam int QW   = CW - 1;
    localparam int DVW  = AW + CW;
    localparam int NFW  = NW + FRAC_BITS;
    localparam int CMPW = (NFW > DVW) ? NFW : DVW;

    localparam int S_TDATA_W = ((9 * CW + RADW) + 7) / 8 * 8;
    localparam int M_TDATA_W = (QW + 7) / 8 * 8;

    typedef struct packed {
        logic                 valid;
        logic                 miss;
        logic signed [HW-1:0] h;
        logic [AW-1:0]        a;
    } sq_side_t;

    typedef struct packed {
        logic valid;
        logic miss;
    } dv_side_t;
endpackage

FILE: rtl/rsnh_isqrt.sv
// Pipelined integer square root, two radicand bits per stage.
module rsnh_isqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  rsnh_pkg::sq_side_t       in_side,
    input  logic [rsnh_pkg::DW-1:0]  in_rad,
    output rsnh_pkg::sq_side_t       out_side,
    output logic [rsnh_pkg::SQW-1:0] out_root
);
    import rsnh_pkg::*;

    sq_side_t         side_reg [SQW];
    logic [DW-1:0]    rad_reg  [SQW];
    logic [SQW+1:0]   rem_reg  [SQW];
    logic [SQW-1:0]   root_reg [SQW];

    for (genvar j = 0; j < SQW; j++) begin : g_stage
        sq_side_t       side_prev;
        logic [DW-1:0]  rad_prev;
        logic [SQW+1:0] rem_prev;
        logic [SQW-1:0] root_prev;
        logic [SQW+3:0] rem_t;
        logic [SQW+3:0] trial;
        logic           ge;
        logic [SQW+3:0] rem_sub;

        if (j == 0) begin : g_first
            assign side_prev = in_side;
            assign rad_prev  = in_rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end else begin : g_next
            assign side_prev = side_reg[j-1];
            assign rad_prev  = rad_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
        end

        assign rem_t   = {rem_prev, rad_prev[DW-1 -: 2]};
        assign trial   = (SQW+4)'({root_prev, 2'b01});
        assign ge      = rem_t >= trial;
        assign rem_sub = ge ? rem_t - trial : rem_t;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[j].valid <= 1'b0;
            end else if (en) begin
                side_reg[j].valid <= side_prev.valid;
            end
            if (en) begin
                side_reg[j].miss <= side_prev.miss;
                side_reg[j].h    <= side_prev.h;
                side_reg[j].a    <= side_prev.a;
                rad_reg[j]       <= rad_prev << 2;
                rem_reg[j]       <= rem_sub[SQW+1:0];
                root_reg[j]      <= {root_prev[SQW-2:0], ge};
            end
        end
    end

    assign out_side = side_reg[SQW-1];
    assign out_root = root_reg[SQW-1];
endmodule

FILE: rtl/rsnh_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rsnh_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  rsnh_pkg::dv_side_t       in_side,
    input  logic [rsnh_pkg::DVW-1:0] in_num,
    input  logic [rsnh_pkg::AW-1:0]  in_den,
    output rsnh_pkg::dv_side_t       out_side,
    output logic [rsnh_pkg::QW-1:0]  out_quo
);
    import rsnh_pkg::*;

    dv_side_t       side_reg [QW];
    logic [DVW-1:0] rem_reg  [QW];
    logic [AW-1:0]  den_reg  [QW];
    logic [QW-1:0]  quo_reg  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        dv_side_t       side_prev;
        logic [DVW-1:0] rem_prev;
        logic [AW-1:0]  den_prev;
        logic [QW-1:0]  quo_prev;
        logic [DVW-1:0] sub;
        logic           ge;

        if (j == 0) begin : g_first
            assign side_prev = in_side;
            assign rem_prev  = in_num;
            assign den_prev  = in_den;
            assign quo_prev  = '0;
        end else begin : g_next
            assign side_prev = side_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign den_prev  = den_reg[j-1];
            assign quo_prev  = quo_reg[j-1];
        end

        assign sub = DVW'(den_prev) << K;
        assign ge  = rem_prev >= sub;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[j].valid <= 1'b0;
            end else if (en) begin
                side_reg[j].valid <= side_prev.valid;
            end
            if (en) begin
                side_reg[j].miss <= side_prev.miss;
                rem_reg[j]       <= ge ? rem_prev - sub : rem_prev;
                den_reg[j]       <= den_prev;
                quo_reg[j]       <= {quo_prev[QW-2:0], ge};
            end
        end
    end

    assign out_side = side_reg[QW-1];
    assign out_quo  = quo_reg[QW-1];
endmodule

FILE: rtl/ray_sphere_nearest_hit_unit.sv
// Ray-sphere nearest hit unit: quadratic setup, discriminant, root and divide pipeline.
//
// channel | dir | contents
// s_      | in  | tdata: origin x/y/z, dir x/y/z, center x/y/z, radius
// m_      | out | tuser: hit; tdata: distance
//
// One transaction enters per cycle while no result is held; the pipeline stages are:
// seven setup stages, one square root stage per root bit, two numerator stages,
// one divide stage per distance bit and the output register.
// Reset clears every stage valid bit. A held result freezes the whole pipeline;
// nothing is dropped or repeated.
module ray_sphere_nearest_hit_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y, center_z, radius
    input  logic [rsnh_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // distance
    output logic [rsnh_pkg::M_TDATA_W-1:0] m_tdata,
    // hit
    output logic                           m_tuser
);
    import rsnh_pkg::*;

    logic en;

    logic                     v1_reg;
    logic signed [LW-1:0]     l_reg [3];
    logic signed [CW-1:0]     d_reg [3];
    logic [RADW-1:0]          r_reg;

    logic                     v2_reg;
    logic signed [2*CW-1:0]   dd_reg [3];
    logic signed [LW+CW-1:0]  ld_reg [3];
    logic signed [2*LW-1:0]   ll_reg [3];
    logic [2*RADW-1:0]        rr_reg;

    logic                     v3_reg;
    logic [AW-1:0]            a3_reg;
    logic signed [HW-1:0]     h3_reg;
    logic signed [CSW-1:0]    c3_reg;

    logic                     v4_reg;
    logic [AW-1:0]            a4_reg;
    logic signed [HW-1:0]     h4_reg;
    logic [MW-1:0]            hm_reg;
    logic [MW-1:0]            cm_reg;
    logic                     cneg4_reg;

    logic                     v5_reg;
    logic [AW-1:0]            a5_reg;
    logic signed [HW-1:0]     h5_reg;
    logic                     cneg5_reg;
    logic [PW-1:0]            hll_reg, hlh_reg, hhh_reg;
    logic [PW-1:0]            all_reg, alh_reg, ahl_reg, ahh_reg;

    logic                     v6_reg;
    logic [AW-1:0]            a6_reg;
    logic signed [HW-1:0]     h6_reg;
    logic                     cneg6_reg;
    logic [DW-1:0]            sq_reg, ac_reg;

    logic                     v7_reg;
    logic [AW-1:0]            a7_reg;
    logic signed [HW-1:0]     h7_reg;
    logic signed [DW-1:0]     disc_reg;

    sq_side_t                 sq_in, sq_out;
    logic [SQW-1:0]           root;

    logic                     v8_reg, miss8_reg;
    logic [AW-1:0]            a8_reg;
    logic [NW-1:0]            n8_reg;

    logic                     v9_reg, miss9_reg;
    logic [AW-1:0]            a9_reg;
    logic [DVW-1:0]           num9_reg;

    dv_side_t                 dv_in, dv_out;
    logic [QW-1:0]            quo;

    logic                     m_valid_reg;
    logic                     hit_reg;
    logic [QW-1:0]            dist_reg;

    logic signed [HW-1:0]     h_abs;
    logic signed [CSW-1:0]    c_abs;
    logic signed [NW-1:0]     nh, s_ext, n1, n2;
    logic                     n_miss;
    logic [NW-1:0]            n_sel;
    logic [CMPW-1:0]          nf, lim;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= sq_out.valid;
            v9_reg <= v8_reg;
            m_valid_reg <= dv_out.valid;
        end
    end

    assign h_abs = h3_reg[HW-1] ? -h3_reg : h3_reg;
    assign c_abs = c3_reg[CSW-1] ? -c3_reg : c3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                l_reg[i] <= LW'($signed(s_tdata[i*CW +: CW]))
                          - LW'($signed(s_tdata[(6+i)*CW +: CW]));
                d_reg[i] <= $signed(s_tdata[(3+i)*CW +: CW]);
            end
            r_reg <= s_tdata[9*CW +: RADW];

            for (int i = 0; i < 3; i++) begin
                dd_reg[i] <= d_reg[i] * d_reg[i];
                ld_reg[i] <= l_reg[i] * d_reg[i];
                ll_reg[i] <= l_reg[i] * l_reg[i];
            end
            rr_reg <= r_reg * r_reg;

            a3_reg <= AW'($unsigned(dd_reg[0])) + AW'($unsigned(dd_reg[1]))
                    + AW'($unsigned(dd_reg[2]));
            h3_reg <= HW'(ld_reg[0]) + HW'(ld_reg[1]) + HW'(ld_reg[2]);
            c3_reg <= CSW'(ll_reg[0]) + CSW'(ll_reg[1]) + CSW'(ll_reg[2])
                    - CSW'($signed({1'b0, rr_reg}));

            a4_reg    <= a3_reg;
            h4_reg    <= h3_reg;
            hm_reg    <= MW'($unsigned(h_abs));
            cm_reg    <= c_abs[MW-1:0];
            cneg4_reg <= c3_reg[CSW-1];

            a5_reg    <= a4_reg;
            h5_reg    <= h4_reg;
            cneg5_reg <= cneg4_reg;
            hll_reg   <= hm_reg[MH-1:0] * hm_reg[MH-1:0];
            hlh_reg   <= hm_reg[MH-1:0] * hm_reg[MW-1:MH];
            hhh_reg   <= hm_reg[MW-1:MH] * hm_reg[MW-1:MH];
            all_reg   <= a4_reg[MH-1:0] * cm_reg[MH-1:0];
            alh_reg   <= a4_reg[MH-1:0] * cm_reg[MW-1:MH];
            ahl_reg   <= a4_reg[AW-1:MH] * cm_reg[MH-1:0];
            ahh_reg   <= a4_reg[AW-1:MH] * cm_reg[MW-1:MH];

            a6_reg    <= a5_reg;
            h6_reg    <= h5_reg;
            cneg6_reg <= cneg5_reg;
            sq_reg    <= (DW'(hhh_reg) << (2*MH)) + (DW'(hlh_reg) << (MH+1)) + DW'(hll_reg);
            ac_reg    <= (DW'(ahh_reg) << (2*MH)) + (DW'(alh_reg) << MH)
                       + (DW'(ahl_reg) << MH) + DW'(all_reg);

            a7_reg    <= a6_reg;
            h7_reg    <= h6_reg;
            disc_reg  <= cneg6_reg ? $signed(sq_reg + ac_reg) : $signed(sq_reg - ac_reg);
        end
    end

    assign sq_in.valid = v7_reg;
    assign sq_in.miss  = (a7_reg == '0) || disc_reg[DW-1];
    assign sq_in.h     = h7_reg;
    assign sq_in.a     = a7_reg;

    rsnh_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_side  (sq_in),
        .in_rad   (disc_reg),
        .out_side (sq_out),
        .out_root (root)
    );

    assign nh    = -NW'(sq_out.h);
    assign s_ext = NW'(root);
    assign n2    = nh - s_ext;
    assign n1    = nh + s_ext;

    always_comb begin
        n_miss = 1'b0;
        n_sel  = '0;
        priority if (!n2[NW-1]) begin
            n_sel = n2;
        end else if (!n1[NW-1]) begin
            n_sel = n1;
        end else begin
            n_miss = 1'b1;
        end
    end

    assign nf  = CMPW'(n8_reg) << FRAC_BITS;
    assign lim = CMPW'(a8_reg) << (CW-1);

    always_ff @(posedge aclk) begin
        if (en) begin
            miss8_reg <= sq_out.miss || n_miss;
            a8_reg    <= sq_out.a;
            n8_reg    <= n_sel;

            miss9_reg <= miss8_reg || (nf >= lim);
            a9_reg    <= a8_reg;
            num9_reg  <= nf[DVW-1:0];
        end
    end

    assign dv_in.valid = v9_reg;
    assign dv_in.miss  = miss9_reg;

    rsnh_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_side  (dv_in),
        .in_num   (num9_reg),
        .in_den   (a9_reg),
        .out_side (dv_out),
        .out_quo  (quo)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg  <= !dv_out.miss;
            dist_reg <= dv_out.miss ? '0 : quo;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = M_TDATA_W'(dist_reg);
endmodule

FILE: sim/ray_sphere_nearest_hit_unit_tb.sv
// Self-checking testbench for the ray-sphere nearest hit unit: directed, random and stall tests.
`timescale 1ns / 100ps

module ray_sphere_nearest_hit_unit_tb;
    import rsnh_pkg::*;

    localparam int  LAT        = 3 * COORD_WIDTH + 11;
    localparam int  BW         = 8 * COORD_WIDTH;
    localparam int  CYCLE_LIMIT = 900000;
    localparam logic [QW-1:0] DMAX = {QW{1'b1}};

    typedef struct packed {
        logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
        logic [RADW-1:0]      r;
    } ray_t;

    typedef struct packed {
        logic          hit;
        logic [QW-1:0] distance;
    } hit_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    hit_t   hits_pending[$];
    int     mismatches = 0;
    int     cycles = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_cycles = 0;

    ray_sphere_nearest_hit_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [BW-1:0] isqrt(input logic [BW-1:0] v);
        logic [BW-1:0] root, cand;
        root = '0;
        for (int k = BW / 2 - 1; k >= 0; k--) begin
            cand = root | (BW'(1) << k);
            if (cand * cand <= v) root = cand;
        end
        return root;
    endfunction

    function automatic hit_t nearest_hit(input ray_t x);
        logic signed [BW-1:0] a, h, c, l, d, disc, s, n;
        logic [BW-1:0]        q;
        hit_t                 res;
        logic signed [CW-1:0] o[3], dv[3], ce[3];
        o  = '{x.ox, x.oy, x.oz};
        dv = '{x.dx, x.dy, x.dz};
        ce = '{x.cx, x.cy, x.cz};
        res = '0;
        a = 0; h = 0; c = 0;
        for (int i = 0; i < 3; i++) begin
            l = BW'(o[i]) - BW'(ce[i]);
            d = BW'(dv[i]);
            a += d * d;
            h += l * d;
            c += l * l;
        end
        c -= BW'(x.r) * BW'(x.r);
        if (a == 0) return res;
        disc = h * h - a * c;
        if (disc < 0) return res;
        s = isqrt(disc);
        if (-h - s >= 0) n = -h - s;
        else if (-h + s >= 0) n = -h + s;
        else return res;
        q = (BW'(n) << FRAC_BITS) / BW'(a);
        if (q > BW'(DMAX)) return res;
        res.hit      = 1'b1;
        res.distance = q[QW-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ray_sphere_nearest_hit_unit_tb: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        hit_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit      = m_tuser;
            got.distance = m_tdata[QW-1:0];
            if (hits_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction hit=%0b distance=%h",
                                               got.hit, got.distance);
            end else begin
                want = hits_pending.pop_front();
                if (got.hit !== want.hit || got.distance !== want.distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0b distance=%h, got hit=%0b distance=%h",
                                 want.hit, want.distance, got.hit, got.distance);
                end
            end
        end
    end

    task automatic send_ray(input ray_t x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({x.r, x.cz, x.cy, x.cx, x.dz, x.dy, x.dx, x.oz, x.oy, x.ox});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hits_pending.push_back(nearest_hit(x));
    endtask

    function automatic logic signed [CW-1:0] q16(input int v);
        return CW'(v) <<< FRAC_BITS;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(input int mode);
        case (mode)
            0: return CW'($urandom);
            1: return q16($urandom_range(40)) - q16(20) + CW'($urandom_range(65535));
            default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // Aim a ray toward a sphere so most items hit; perturb to get misses and tangents.
    function automatic ray_t rand_ray();
        ray_t x;
        int   mode;
        mode = $urandom_range(9);
        x.cx = rand_coord(mode == 0 ? 0 : 1);
        x.cy = rand_coord(mode == 0 ? 0 : 1);
        x.cz = rand_coord(mode == 0 ? 0 : 1);
        x.ox = rand_coord(mode == 1 ? 0 : 1);
        x.oy = rand_coord(mode == 1 ? 0 : 1);
        x.oz = rand_coord(mode == 1 ? 0 : 1);
        if (mode <= 2) begin
            x.dx = CW'($urandom); x.dy = CW'($urandom); x.dz = CW'($urandom);
            x.r  = RADW'($urandom);
        end else begin
            x.dx = ((x.cx - x.ox) >>> $urandom_range(4)) + CW'($urandom_range(255));
            x.dy = (x.cy - x.oy) >>> $urandom_range(4);
            x.dz = (x.cz - x.oz) >>> $urandom_range(4);
            if ($urandom_range(1)) x.dx = -x.dx;
            x.r  = RADW'(q16($urandom_range(10))) + RADW'($urandom_range(65535));
        end
        if (mode == 3) x.r = RADW'($urandom) | RADW'(1 << 30);
        return x;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (hits_pending.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
    endtask

    task automatic test_directed();
        ray_t x;
        x = '0; x.dz = q16(1); x.cz = q16(5); x.r = RADW'(q16(1));
        send_ray(x);                                 // two roots in front
        x.oz = q16(5); send_ray(x);                  // origin inside
        x.oz = q16(10); send_ray(x);                 // sphere behind
        x.oz = q16(4); send_ray(x);                  // t = 0 exactly
        x = '0; x.cz = q16(5); x.r = RADW'(q16(1)); send_ray(x);   // zero direction
        x = '0; x.dz = q16(1); x.cz = q16(5); x.cx = q16(1);
        x.r = RADW'(q16(1)); send_ray(x);            // tangent
        x.cx = q16(3); send_ray(x);                  // miss
        x = '0; x.dz = 1; x.cz = 32'sh7FFF_0000; x.r = RADW'(1); send_ray(x);  // overflow
        x = '0; x.dz = 32'sh8000_0000; x.oz = 32'sh7FFF_FFFF; x.r = DMAX;
        send_ray(x);
        x = '1; x.r = DMAX; send_ray(x);
        x = '0; send_ray(x);
        x = '0; x.dx = 32'sh7FFF_FFFF; x.dy = 32'sh8000_0000; x.dz = 32'sh7FFF_FFFF;
        x.cx = 32'sh8000_0000; x.ox = 32'sh7FFF_FFFF; x.r = DMAX; send_ray(x);
        x = '0; x.dx = 1; x.cx = q16(2); x.r = RADW'(q16(1)); send_ray(x);
        for (int i = 0; i < 6; i++) begin
            x = '0;
            {x.ox, x.oy, x.oz, x.dx, x.dy, x.dz, x.cx, x.cy, x.cz} = {9{32'hAAAA_5555}} >> i;
            x.r = RADW'({16{2'b01}} << (i % 2));
            send_ray(x);
        end
        drain();
    endtask

    task automatic test_random(input int n, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++) send_ray(rand_ray());
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles <= 3 * LAT;
        for (int i = 0; i < 3 * LAT / 2; i++) send_ray(rand_ray());
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(230, 8, 66);
        test_random(230, 66, 8);
        test_random(130, 0, 0);
        test_backpressure();
        if (mismatches == 0) $display("ray_sphere_nearest_hit_unit_tb: PASS");
        else $display("ray_sphere_nearest_hit_unit_tb: FAIL");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/rsnh_pkg.sv
rtl/rsnh_isqrt.sv
rtl/rsnh_div.sv
rtl/ray_sphere_nearest_hit_unit.sv
sim/ray_sphere_nearest_hit_unit_tb.sv
